FILE: src/circular_list_with_cursor_defines.svh
// ---------------------------------------------------------------------------
// Circular list assertion macros
// Shared concurrent assertion forms, clocked on clk_i and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef CIRCULAR_LIST_WITH_CURSOR_DEFINES_SVH
`define CIRCULAR_LIST_WITH_CURSOR_DEFINES_SVH

// Plain clocked property with reset disable.
`define CCL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication.
`define CCL_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  `CCL_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

FILE: src/ccl_pkg.sv
// ---------------------------------------------------------------------------
// Circular list package
// Defaults, operation and status codes, and the free map control word.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package ccl_pkg;

  localparam int CapacityDef  = 32;
  localparam int DataWidthDef = 16;
  // widest node index over the supported capacity range
  localparam int IdxMaxW      = 6;

  localparam logic [2:0] OP_EMPTY_Q   = 3'd0;
  localparam logic [2:0] OP_INS_AFTER = 3'd1;
  localparam logic [2:0] OP_INS_BEFOR = 3'd2;
  localparam logic [2:0] OP_DEL_AFTER = 3'd3;
  localparam logic [2:0] OP_DEL_BEFOR = 3'd4;
  localparam logic [2:0] OP_DEL_CUR   = 3'd5;
  localparam logic [2:0] OP_SHOW      = 3'd6;
  localparam logic [2:0] OP_CLEAR     = 3'd7;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic               clear_all;
    logic               alloc_en;
    logic [IdxMaxW-1:0] alloc_idx;
    logic               release_en;
    logic [IdxMaxW-1:0] release_idx;
  } fm_ctrl_t;

endpackage
`default_nettype wire

FILE: src/ccl_ram.sv
// ---------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data held when not read.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module ccl_ram #(
  parameter int Width = 16,
  parameter int Depth = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

FILE: src/ccl_free_map.sv
// ---------------------------------------------------------------------------
// Free map
// One free bit per node and a registered lowest-free-node index.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module ccl_free_map #(
  parameter int Capacity = 32,
  localparam int IdxW    = $clog2(Capacity)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire ccl_pkg::fm_ctrl_t ctrl_i,
  output logic      [IdxW-1:0]  alloc_idx_o
);
  import ccl_pkg::*;

  logic [Capacity-1:0] free_q, free_d;
  logic [IdxW-1:0]     alloc_q, alloc_d;

  always_comb begin
    free_d = free_q;
    if (ctrl_i.clear_all) begin
      free_d = '1;
    end else begin
      if (ctrl_i.alloc_en) begin
        free_d[ctrl_i.alloc_idx[IdxW-1:0]] = 1'b0;
      end
      if (ctrl_i.release_en) begin
        free_d[ctrl_i.release_idx[IdxW-1:0]] = 1'b1;
      end
    end
  end

  // lowest free entry, registered; the sequencer never asks before it has settled
  always_comb begin
    alloc_d = '0;
    for (int i = Capacity - 1; i >= 0; i--) begin
      if (free_q[i]) begin
        alloc_d = IdxW'(i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_q  <= '1;
      alloc_q <= '0;
    end else begin
      free_q  <= free_d;
      alloc_q <= alloc_d;
    end
  end

  assign alloc_idx_o = alloc_q;

endmodule
`default_nettype wire

FILE: src/circular_list_with_cursor.sv
// ---------------------------------------------------------------------------
// Circular list with cursor
// Bounded circular singly linked list in a value RAM and a link RAM.
// ---------------------------------------------------------------------------
// Empty queries, clears and refused ops give a single result word; a show
// streams one word per cycle while the output is not stalled. Inserts relink the
// ring; insert before and delete cursor first walk to the cursor's predecessor,
// delete before walks twice, and a walk follows the links one at a time.
// One word at a time; next word accepted the cycle after its last result loads.
// Reset empties the list and frees every node at once; the RAMs are not swept.
`timescale 1ns / 1ps
`default_nettype none
module circular_list_with_cursor #(
  parameter int CAPACITY   = ccl_pkg::CapacityDef,
  parameter int DATA_WIDTH = ccl_pkg::DataWidthDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [2:0]  operation_i,
  input  wire logic [15:0] item_value_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic      [15:0] out_value_o,
  output logic             list_empty_o,
  output logic      [1:0]  status_o,
  output logic             last_of_run_o
);
  import ccl_pkg::*;

  localparam int IdxW = $clog2(CAPACITY);
  localparam int CntW = $clog2(CAPACITY + 1);

  // sequencer states
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_WALK = 4'd1;   // search predecessor of tgt_q
  localparam logic [3:0] S_INA  = 4'd2;   // insert after: link new node
  localparam logic [3:0] S_INA2 = 4'd3;   // insert after: relink cursor
  localparam logic [3:0] S_INB  = 4'd4;   // insert before: relink predecessor
  localparam logic [3:0] S_CRD  = 4'd5;   // read cursor value
  localparam logic [3:0] S_CVAL = 4'd6;   // emit cursor value
  localparam logic [3:0] S_DA   = 4'd7;   // delete after: victim is next
  localparam logic [3:0] S_DRD  = 4'd8;   // read victim node
  localparam logic [3:0] S_DWR  = 4'd9;   // unlink victim
  localparam logic [3:0] S_EMIT = 4'd10;  // emit registered value
  localparam logic [3:0] S_SHOW = 4'd11;  // stream the ring

  logic [3:0]            state_q, state_d;
  logic [2:0]            op_q, op_d;
  logic [DATA_WIDTH-1:0] val_q, val_d;
  logic [IdxW-1:0]       cur_q, cur_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic [IdxW-1:0]       node_q, node_d;
  logic [IdxW-1:0]       p_q, p_d;
  logic [IdxW-1:0]       tgt_q, tgt_d;
  logic [IdxW-1:0]       victim_q, victim_d;
  logic [IdxW-1:0]       k_q, k_d;
  logic [CntW-1:0]       rem_q, rem_d;
  logic                  phase_q, phase_d;
  logic [1:0]            st_q, st_d;
  logic [DATA_WIDTH-1:0] emit_q, emit_d;

  logic                  out_valid_q;
  logic [15:0]           out_value_q;
  logic                  out_empty_q;
  logic [1:0]            out_status_q;
  logic                  out_last_q;

  // RAM ports
  logic                  v_we, v_re;
  logic [IdxW-1:0]       v_waddr, v_raddr;
  logic [DATA_WIDTH-1:0] v_wdata, v_rdata;
  logic                  l_we, l_re;
  logic [IdxW-1:0]       l_waddr, l_raddr, l_wdata, l_rdata;

  fm_ctrl_t              fm_ctrl;
  logic [IdxW-1:0]       alloc_idx;

  logic                  can_load, load, ld_last, accept, found;
  logic [DATA_WIDTH-1:0] ld_value;

  ccl_ram #(.Width(DATA_WIDTH), .Depth(CAPACITY)) u_values (
    .clk_i   (clk_i),
    .we_i    (v_we),
    .waddr_i (v_waddr),
    .wdata_i (v_wdata),
    .re_i    (v_re),
    .raddr_i (v_raddr),
    .rdata_o (v_rdata)
  );

  ccl_ram #(.Width(IdxW), .Depth(CAPACITY)) u_links (
    .clk_i   (clk_i),
    .we_i    (l_we),
    .waddr_i (l_waddr),
    .wdata_i (l_wdata),
    .re_i    (l_re),
    .raddr_i (l_raddr),
    .rdata_o (l_rdata)
  );

  ccl_free_map #(.Capacity(CAPACITY)) u_free_map (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (fm_ctrl),
    .alloc_idx_o (alloc_idx)
  );

  // output register frees as it is taken, so a new word may load each cycle
  assign can_load   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  // the walk stops on a match; the step bound only guards against a broken ring
  assign found      = (l_rdata == tgt_q) || (k_q == IdxW'(CAPACITY - 1));

  always_comb begin
    state_d  = state_q;
    op_d     = op_q;
    val_d    = val_q;
    cur_d    = cur_q;
    cnt_d    = cnt_q;
    node_d   = node_q;
    p_d      = p_q;
    tgt_d    = tgt_q;
    victim_d = victim_q;
    k_d      = k_q;
    rem_d    = rem_q;
    phase_d  = phase_q;
    st_d     = st_q;
    emit_d   = emit_q;

    v_we = 1'b0;  v_waddr = node_q;  v_wdata = val_q;
    v_re = 1'b0;  v_raddr = cur_q;
    l_we = 1'b0;  l_waddr = node_q;  l_wdata = cur_q;
    l_re = 1'b0;  l_raddr = cur_q;

    fm_ctrl             = '0;
    fm_ctrl.alloc_idx   = IdxMaxW'(alloc_idx);
    fm_ctrl.release_idx = IdxMaxW'(victim_q);

    load     = 1'b0;
    ld_value = emit_q;
    ld_last  = 1'b1;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_d    = operation_i;
          val_d   = DATA_WIDTH'(item_value_i);
          st_d    = ST_OK;
          emit_d  = '0;
          phase_d = 1'b0;
          k_d     = '0;
          unique case (operation_i)
            OP_EMPTY_Q: begin
              // cursor value, or zero on an empty list
              v_re    = 1'b1;
              state_d = (cnt_q == '0) ? S_EMIT : S_CVAL;
            end
            OP_INS_AFTER, OP_INS_BEFOR: begin
              if (cnt_q == CntW'(CAPACITY)) begin
                st_d    = ST_FULL;
                v_re    = 1'b1;
                state_d = S_CVAL;
              end else begin
                // take a free node and store the value right away
                node_d           = alloc_idx;
                fm_ctrl.alloc_en = 1'b1;
                v_we             = 1'b1;
                v_waddr          = alloc_idx;
                v_wdata          = DATA_WIDTH'(item_value_i);
                if (cnt_q == '0) begin
                  // one-node ring, new node becomes the cursor
                  l_we    = 1'b1;
                  l_waddr = alloc_idx;
                  l_wdata = alloc_idx;
                  cur_d   = alloc_idx;
                  cnt_d   = cnt_q + CntW'(1);
                  state_d = S_CRD;
                end else if (operation_i == OP_INS_AFTER) begin
                  l_re    = 1'b1;
                  state_d = S_INA;
                end else begin
                  l_re    = 1'b1;
                  p_d     = cur_q;
                  tgt_d   = cur_q;
                  state_d = S_WALK;
                end
              end
            end
            OP_DEL_AFTER, OP_DEL_BEFOR, OP_DEL_CUR: begin
              if (cnt_q == '0) begin
                st_d    = ST_EMPTY;
                state_d = S_EMIT;
              end else begin
                l_re     = 1'b1;
                p_d      = cur_q;
                tgt_d    = cur_q;
                victim_d = cur_q;
                state_d  = (operation_i == OP_DEL_AFTER) ? S_DA : S_WALK;
              end
            end
            OP_SHOW: begin
              if (cnt_q == '0) begin
                state_d = S_EMIT;
              end else begin
                v_re    = 1'b1;
                l_re    = 1'b1;
                rem_d   = cnt_q;
                state_d = S_SHOW;
              end
            end
            OP_CLEAR: begin
              fm_ctrl.clear_all = 1'b1;
              cnt_d   = '0;
              cur_d   = '0;
              state_d = S_EMIT;
            end
          endcase
        end
      end

      S_WALK: begin
        if (found) begin
          priority if (op_q == OP_INS_BEFOR) begin
            l_we    = 1'b1;
            l_waddr = node_q;
            l_wdata = cur_q;
            state_d = S_INB;
          end else if (op_q == OP_DEL_BEFOR && !phase_q) begin
            // victim is the cursor's predecessor; now find its predecessor
            victim_d = p_q;
            tgt_d    = p_q;
            phase_d  = 1'b1;
            k_d      = '0;
            l_re     = 1'b1;
            l_raddr  = p_q;
          end else begin
            state_d = S_DRD;
          end
        end else begin
          // advance one link
          p_d     = l_rdata;
          l_re    = 1'b1;
          l_raddr = l_rdata;
          k_d     = k_q + IdxW'(1);
        end
      end

      S_INA: begin
        l_we    = 1'b1;
        l_waddr = node_q;
        l_wdata = l_rdata;
        state_d = S_INA2;
      end

      S_INA2: begin
        l_we    = 1'b1;
        l_waddr = cur_q;
        l_wdata = node_q;
        cnt_d   = cnt_q + CntW'(1);
        state_d = S_CRD;
      end

      S_INB: begin
        l_we    = 1'b1;
        l_waddr = p_q;
        l_wdata = node_q;
        cnt_d   = cnt_q + CntW'(1);
        state_d = S_CRD;
      end

      S_CRD: begin
        v_re    = 1'b1;
        state_d = S_CVAL;
      end

      S_CVAL: begin
        if (can_load) begin
          load     = 1'b1;
          ld_value = v_rdata;
          state_d  = S_IDLE;
        end
      end

      S_DA: begin
        // predecessor of the cursor's successor is the cursor itself
        victim_d = l_rdata;
        p_d      = cur_q;
        state_d  = S_DRD;
      end

      S_DRD: begin
        v_re    = 1'b1;
        v_raddr = victim_q;
        l_re    = 1'b1;
        l_raddr = victim_q;
        state_d = S_DWR;
      end

      S_DWR: begin
        // bridge the predecessor over the victim and free it
        l_we               = 1'b1;
        l_waddr            = p_q;
        l_wdata            = l_rdata;
        emit_d             = v_rdata;
        fm_ctrl.release_en = 1'b1;
        cnt_d              = cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          cur_d = '0;
        end else if (victim_q == cur_q) begin
          cur_d = l_rdata;
        end
        state_d = S_EMIT;
      end

      S_EMIT: begin
        if (can_load) begin
          load    = 1'b1;
          state_d = S_IDLE;
        end
      end

      S_SHOW: begin
        // RAM data holds while the output stalls
        if (can_load) begin
          load     = 1'b1;
          ld_value = v_rdata;
          ld_last  = (rem_q == CntW'(1));
          if (rem_q == CntW'(1)) begin
            state_d = S_IDLE;
          end else begin
            v_re    = 1'b1;
            v_raddr = l_rdata;
            l_re    = 1'b1;
            l_raddr = l_rdata;
            rem_d   = rem_q - CntW'(1);
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cur_q       <= '0;
      cnt_q       <= '0;
      k_q         <= '0;
      rem_q       <= '0;
      phase_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cur_q   <= cur_d;
      cnt_q   <= cnt_d;
      k_q     <= k_d;
      rem_q   <= rem_d;
      phase_q <= phase_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    val_q    <= val_d;
    node_q   <= node_d;
    p_q      <= p_d;
    tgt_q    <= tgt_d;
    victim_q <= victim_d;
    st_q     <= st_d;
    emit_q   <= emit_d;
    if (load) begin
      out_value_q  <= 16'(ld_value);
      out_empty_q  <= (cnt_q == '0);
      out_status_q <= st_q;
      out_last_q   <= ld_last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_value_o   = out_value_q;
  assign list_empty_o  = out_empty_q;
  assign status_o      = out_status_q;
  assign last_of_run_o = out_last_q;

endmodule
`default_nettype wire

FILE: src/ccl_checker.sv
// ---------------------------------------------------------------------------
// Circular list checker
// Port-level properties of the circular list, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "circular_list_with_cursor_defines.svh"
module ccl_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_ready_o,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [15:0] out_value_o,
  input wire logic        list_empty_o,
  input wire logic [1:0]  status_o,
  input wire logic        last_of_run_o
);
  import ccl_pkg::*;

  logic out_stall, mid_listing, del_refused, ins_refused;

  assign out_stall   = out_valid_o && !out_ready_i;
  assign mid_listing = out_valid_o && !last_of_run_o;
  assign del_refused = out_valid_o && (status_o == ST_EMPTY);
  assign ins_refused = out_valid_o && (status_o == ST_FULL);

  // a stalled result word holds
  `CCL_ASSERT(a_out_hold, out_stall |=> out_valid_o && $stable(out_value_o), "stalled word moved")
  // no new word is taken in the middle of a ring listing
  `CCL_ASSERT_IMPLIES(a_show_busy, mid_listing, !in_ready_o, "input taken during a listing")
  // a refused delete leaves the list empty
  `CCL_ASSERT_IMPLIES(a_empty_flag, del_refused, list_empty_o && last_of_run_o, "bad empty status")
  // a refused insert means the list holds elements
  `CCL_ASSERT_IMPLIES(a_full_flag, ins_refused, !list_empty_o && last_of_run_o, "bad full status")

endmodule

bind circular_list_with_cursor ccl_checker u_ccl_checker (.*);
`default_nettype wire
